>>> hw/rtl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_INV  = 3'd4,
        OP_CONJ = 3'd5,
        OP_MAG  = 3'd6,
        OP_ARG  = 3'd7
    } t_op;

    // angle unit: 2^-30 rad
    localparam int ANG_STEPS = 30;
    localparam int NORM_MSB  = 40;
    localparam int ANG_W     = 34;
    localparam int CX_W      = 45;
    localparam int Z_W       = 34;

    localparam logic [ANG_W-1:0] PI_Q30      = 34'd3373259426;
    localparam logic [ANG_W-1:0] TWO_PI_Q30  = 34'd6746518852;
    localparam logic [ANG_W-1:0] HALF_PI_Q30 = 34'd1686629713;

    typedef struct packed {
        t_op  op;
        logic zf;
        logic ovf_s;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
        logic a_re_neg;
        logic a_im_neg;
        logic x_zero;
        logic y_zero;
    } t_ctrl;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd843314857;
            1:       v = 32'd497837829;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021687;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            default: v = (idx < ANG_STEPS) ? (32'd1 << (30 - idx)) : 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/cau_cell.sv
// One step cell: a divide bit on two lanes, a root bit, and a rotation step.
module cau_cell #(
    parameter int W   = 32,
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [2*W:0]                        i_den,
    input  logic [2*W:0]                        i_rem_re,
    input  logic [W-1:0]                        i_nq_re,
    input  logic [2*W:0]                        i_rem_im,
    input  logic [W-1:0]                        i_nq_im,
    input  logic [2*W-1:0]                      i_sq,
    input  logic [W-1:0]                        i_root,
    input  logic [W:0]                          i_srem,
    input  logic signed [cau_pkg::CX_W-1:0]     i_x,
    input  logic signed [cau_pkg::CX_W-1:0]     i_y,
    input  logic signed [cau_pkg::Z_W-1:0]      i_z,
    output logic [2*W:0]                        o_den,
    output logic [2*W:0]                        o_rem_re,
    output logic [W-1:0]                        o_nq_re,
    output logic [2*W:0]                        o_rem_im,
    output logic [W-1:0]                        o_nq_im,
    output logic [2*W-1:0]                      o_sq,
    output logic [W-1:0]                        o_root,
    output logic [W:0]                          o_srem,
    output logic signed [cau_pkg::CX_W-1:0]     o_x,
    output logic signed [cau_pkg::CX_W-1:0]     o_y,
    output logic signed [cau_pkg::Z_W-1:0]      o_z
);

    localparam int DW = 2 * W + 1;
    localparam logic signed [cau_pkg::Z_W-1:0] ATAN =
        $signed(cau_pkg::Z_W'(cau_pkg::atan_q30(IDX)));

    logic [DW-1:0]                  r_den, n_den, r_rem_re, n_rem_re, r_rem_im, n_rem_im;
    logic [W-1:0]                   r_nq_re, n_nq_re, r_nq_im, n_nq_im, r_root, n_root;
    logic [2*W-1:0]                 r_sq, n_sq;
    logic [W:0]                     r_srem, n_srem;
    logic signed [cau_pkg::CX_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [cau_pkg::Z_W-1:0]  r_z, n_z;

    logic [DW:0]  t_re, t_im;
    logic [W+2:0] st, trial;
    logic signed [cau_pkg::CX_W-1:0] dx, dy;

    always_comb begin
        n_den    = i_den;
        n_rem_re = i_rem_re;
        n_nq_re  = i_nq_re;
        n_rem_im = i_rem_im;
        n_nq_im  = i_nq_im;
        n_sq     = i_sq;
        n_root   = i_root;
        n_srem   = i_srem;
        n_x      = i_x;
        n_y      = i_y;
        n_z      = i_z;
        t_re     = {i_rem_re, i_nq_re[W-1]};
        t_im     = {i_rem_im, i_nq_im[W-1]};
        st       = {i_srem, i_sq[2*W-1 -: 2]};
        trial    = {1'b0, i_root, 2'b01};
        dx       = i_y >>> IDX;
        dy       = i_x >>> IDX;
        if (IDX < W) begin
            // restoring divide: shift in the next numerator bit, take the quotient bit
            if (t_re >= {1'b0, i_den}) begin
                n_rem_re = DW'(t_re - {1'b0, i_den});
                n_nq_re  = {i_nq_re[W-2:0], 1'b1};
            end else begin
                n_rem_re = t_re[DW-1:0];
                n_nq_re  = {i_nq_re[W-2:0], 1'b0};
            end
            if (t_im >= {1'b0, i_den}) begin
                n_rem_im = DW'(t_im - {1'b0, i_den});
                n_nq_im  = {i_nq_im[W-2:0], 1'b1};
            end else begin
                n_rem_im = t_im[DW-1:0];
                n_nq_im  = {i_nq_im[W-2:0], 1'b0};
            end
            // root digit: two radicand bits in, one root bit out
            if (st >= trial) begin
                n_srem = (W+1)'(st - trial);
                n_root = {i_root[W-2:0], 1'b1};
            end else begin
                n_srem = st[W:0];
                n_root = {i_root[W-2:0], 1'b0};
            end
            n_sq = {i_sq[2*W-3:0], 2'b00};
        end
        if (IDX < cau_pkg::ANG_STEPS) begin
            // vectoring rotation toward the x axis
            if (!i_y[cau_pkg::CX_W-1] && (i_y != '0)) begin
                n_x = i_x + dx;
                n_y = i_y - dy;
                n_z = i_z + ATAN;
            end else begin
                n_x = i_x - dx;
                n_y = i_y + dy;
                n_z = i_z - ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den    <= n_den;
            r_rem_re <= n_rem_re;
            r_nq_re  <= n_nq_re;
            r_rem_im <= n_rem_im;
            r_nq_im  <= n_nq_im;
            r_sq     <= n_sq;
            r_root   <= n_root;
            r_srem   <= n_srem;
            r_x      <= n_x;
            r_y      <= n_y;
            r_z      <= n_z;
        end
    end

    assign o_den    = r_den;
    assign o_rem_re = r_rem_re;
    assign o_nq_re  = r_nq_re;
    assign o_rem_im = r_rem_im;
    assign o_nq_im  = r_nq_im;
    assign o_sq     = r_sq;
    assign o_root   = r_root;
    assign o_srem   = r_srem;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_z      = r_z;

endmodule

>>> hw/rtl/complex_arith_unit_top.sv
// Top level of the complex arithmetic unit: front stages, cell row, result stage.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------------
//   request  | i_valid / o_ready  | i_req_type, i_a_re, i_a_im, i_b_re, i_b_im
//   result   | o_valid / i_ready  | o_res_re, o_res_im, o_zero_operand, o_overflow
//
// Takes one item per cycle while the pipe is not held. It has four front stages
// (products, sums, magnitudes, divide and angle setup), the row of NC step cells,
// NC = max(DATA_WIDTH, 30), and the output register.
// The row length is set by the quotient and root bit count and the 30 rotations.
// The whole pipe holds while a result waits and i_ready is low.
// Reset clears only the valid bits; payload registers carry no reset.
module complex_arith_unit_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic                         o_zero_operand,
    output logic                         o_overflow
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int SW   = PW + 1;
    localparam int NW   = (SW + F > W + 2 * F + 1) ? SW + F : W + 2 * F + 1;
    localparam int UW   = NW + 2;
    localparam int DW   = PW + 1;
    localparam int QW   = UW - W;
    localparam int CW   = (QW > DW) ? QW : DW;
    localparam int MW   = SW + 1;
    localparam int NC   = (W > cau_pkg::ANG_STEPS) ? W : cau_pkg::ANG_STEPS;
    localparam int PBW  = $clog2(W);
    localparam int EXW  = W + cau_pkg::NORM_MSB + 1;
    localparam int CTW  = $bits(cau_pkg::t_ctrl);
    localparam int SBW  = CTW + 2 * W;
    localparam int RSH  = 30 - F;
    localparam int RW   = cau_pkg::ANG_W + 1;

    localparam logic [W-1:0]  MAXV   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINV   = {1'b1, {(W-1){1'b0}}};
    localparam logic [MW-1:0] HALF_F = MW'(1) << (F - 1);
    localparam logic [RW-1:0] HALF_T = (RW'(1) << RSH) >> 1;
    localparam logic [RW-1:0] FULL   = (RW'(cau_pkg::TWO_PI_Q30) + HALF_T) >> RSH;

    // saturate a sign and magnitude pair; returns {overflow, value}
    function automatic logic [W:0] sat_sm(input logic neg, input logic big,
                                          input logic [W-1:0] mag);
        logic [W:0] res;
        if (big) begin
            res = {1'b1, neg ? MINV : MAXV};
        end else if (!neg) begin
            res = (mag > MAXV) ? {1'b1, MAXV} : {1'b0, mag};
        end else begin
            res = (mag > MINV) ? {1'b1, MINV} : {1'b0, W'(~mag + 1'b1)};
        end
        return res;
    endfunction

    function automatic logic [W:0] sat_wide1(input logic signed [W:0] s);
        logic [W:0] a;
        a = s[W] ? (~s + 1'b1) : s;
        return sat_sm(s[W], a[W], a[W-1:0]);
    endfunction

    function automatic logic [W:0] mul_round(input logic signed [SW-1:0] m);
        logic [SW-1:0] a;
        logic [MW-1:0] q;
        a = m[SW-1] ? (~m + 1'b1) : m;
        q = (MW'(a) + HALF_F) >> F;
        return sat_sm(m[SW-1], |(q >> W), q[W-1:0]);
    endfunction

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // ---------------- stage 1: products and operand magnitudes
    logic                 r1_v;
    cau_pkg::t_op         r1_op;
    logic signed [W-1:0]  r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [PW-1:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir;
    logic signed [PW-1:0] r1_p_aa, r1_p_jj, r1_p_bb, r1_p_cc;
    logic [W-1:0]         r1_absx, r1_absy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op   <= cau_pkg::t_op'(i_req_type);
            r1_ar   <= i_a_re;
            r1_ai   <= i_a_im;
            r1_br   <= i_b_re;
            r1_bi   <= i_b_im;
            r1_p_rr <= i_a_re * i_b_re;
            r1_p_ii <= i_a_im * i_b_im;
            r1_p_ri <= i_a_re * i_b_im;
            r1_p_ir <= i_a_im * i_b_re;
            r1_p_aa <= i_a_re * i_a_re;
            r1_p_jj <= i_a_im * i_a_im;
            r1_p_bb <= i_b_re * i_b_re;
            r1_p_cc <= i_b_im * i_b_im;
            r1_absx <= i_a_re[W-1] ? (~i_a_re + 1'b1) : i_a_re;
            r1_absy <= i_a_im[W-1] ? (~i_a_im + 1'b1) : i_a_im;
        end
    end

    // ---------------- stage 2: sums, divide numerators, leading bit of |a|
    logic                 r2_v;
    cau_pkg::t_op         r2_op;
    logic signed [W-1:0]  r2_ar, r2_ai, r2_br, r2_bi;
    logic signed [SW-1:0] r2_mre, r2_mim;
    logic signed [NW-1:0] r2_nre, r2_nim, n2_nre, n2_nim;
    logic [PW-1:0]        r2_d, n2_d;
    logic [W-1:0]         r2_absx, r2_absy, m_or;
    logic [PBW-1:0]       r2_p, n2_p;

    always_comb begin
        n2_nre = '0;
        n2_nim = '0;
        unique case (r1_op)
            cau_pkg::OP_DIV: begin
                n2_nre = NW'(SW'(r1_p_rr) + SW'(r1_p_ii)) << F;
                n2_nim = NW'(SW'(r1_p_ir) - SW'(r1_p_ri)) << F;
            end
            cau_pkg::OP_INV: begin
                n2_nre = NW'(r1_ar) << (2 * F);
                n2_nim = (-NW'(r1_ai)) << (2 * F);
            end
            default: ;
        endcase
        if (r1_op == cau_pkg::OP_DIV) begin
            n2_d = PW'($unsigned(r1_p_bb) + $unsigned(r1_p_cc));
        end else begin
            n2_d = PW'($unsigned(r1_p_aa) + $unsigned(r1_p_jj));
        end
        // leading one of |a_re| | |a_im|
        m_or = r1_absx | r1_absy;
        n2_p = '0;
        for (int i = 0; i < W; i++) begin
            if (m_or[i]) begin
                n2_p = PBW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op   <= r1_op;
            r2_ar   <= r1_ar;
            r2_ai   <= r1_ai;
            r2_br   <= r1_br;
            r2_bi   <= r1_bi;
            r2_mre  <= SW'(r1_p_rr) - SW'(r1_p_ii);
            r2_mim  <= SW'(r1_p_ri) + SW'(r1_p_ir);
            r2_nre  <= n2_nre;
            r2_nim  <= n2_nim;
            r2_d    <= n2_d;
            r2_absx <= r1_absx;
            r2_absy <= r1_absy;
            r2_p    <= n2_p;
        end
    end

    // ---------------- stage 3: simple results, numerator magnitudes
    logic                 r3_v;
    cau_pkg::t_op         r3_op;
    logic                 r3_zf, r3_ovf_s, r3_neg_re, r3_neg_im, r3_a_re_neg, r3_a_im_neg;
    logic [W-1:0]         r3_sre, r3_sim;
    logic [NW-1:0]        r3_are, r3_aim;
    logic [PW-1:0]        r3_d;
    logic [W-1:0]         r3_absx, r3_absy;
    logic [PBW-1:0]       r3_p;
    logic                 n3_zf;
    logic [W:0]           n3_re, n3_im;

    always_comb begin
        n3_zf = (r2_d == '0) && ((r2_op == cau_pkg::OP_DIV) || (r2_op == cau_pkg::OP_INV));
        n3_re = '0;
        n3_im = '0;
        unique case (r2_op)
            cau_pkg::OP_ADD: begin
                n3_re = sat_wide1((W+1)'(r2_ar) + (W+1)'(r2_br));
                n3_im = sat_wide1((W+1)'(r2_ai) + (W+1)'(r2_bi));
            end
            cau_pkg::OP_SUB: begin
                n3_re = sat_wide1((W+1)'(r2_ar) - (W+1)'(r2_br));
                n3_im = sat_wide1((W+1)'(r2_ai) - (W+1)'(r2_bi));
            end
            cau_pkg::OP_MUL: begin
                n3_re = mul_round(r2_mre);
                n3_im = mul_round(r2_mim);
            end
            cau_pkg::OP_CONJ: begin
                n3_re = {1'b0, r2_ar};
                n3_im = sat_wide1(-(W+1)'(r2_ai));
            end
            cau_pkg::OP_INV: begin
                // zero operand hands a back unchanged
                n3_re = {1'b0, r2_ar};
                n3_im = {1'b0, r2_ai};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_op       <= r2_op;
            r3_zf       <= n3_zf;
            r3_ovf_s    <= n3_re[W] | n3_im[W];
            r3_sre      <= n3_re[W-1:0];
            r3_sim      <= n3_im[W-1:0];
            r3_neg_re   <= r2_nre[NW-1];
            r3_neg_im   <= r2_nim[NW-1];
            r3_are      <= r2_nre[NW-1] ? (~r2_nre + 1'b1) : r2_nre;
            r3_aim      <= r2_nim[NW-1] ? (~r2_nim + 1'b1) : r2_nim;
            r3_d        <= r2_d;
            r3_absx     <= r2_absx;
            r3_absy     <= r2_absy;
            r3_p        <= r2_p;
            r3_a_re_neg <= r2_ar[W-1];
            r3_a_im_neg <= r2_ai[W-1];
        end
    end

    // ---------------- stage 4: divide setup, angle normalization
    logic                          r4_v;
    cau_pkg::t_ctrl                r4_ctrl, n4_ctrl;
    logic [W-1:0]                  r4_sre, r4_sim;
    logic [DW-1:0]                 r4_den, r4_rem_re, r4_rem_im;
    logic [W-1:0]                  r4_nq_re, r4_nq_im;
    logic [PW-1:0]                 r4_sq;
    logic signed [cau_pkg::CX_W-1:0] r4_x, r4_y;
    logic [UW-1:0]                 num_re, num_im;
    logic [DW-1:0]                 den;
    logic [CW-1:0]                 hi_re, hi_im;
    logic [EXW-1:0]                xe, ye, xs, ys;

    always_comb begin
        num_re = (UW'(r3_are) << 1) + UW'(r3_d);
        num_im = (UW'(r3_aim) << 1) + UW'(r3_d);
        den    = DW'(r3_d) << 1;
        hi_re  = CW'(num_re >> W);
        hi_im  = CW'(num_im >> W);
        xe     = EXW'(r3_absx);
        ye     = EXW'(r3_absy);
        // place the leading one of the larger side at the fixed top bit
        if (int'(r3_p) >= cau_pkg::NORM_MSB) begin
            xs = xe >> (int'(r3_p) - cau_pkg::NORM_MSB);
            ys = ye >> (int'(r3_p) - cau_pkg::NORM_MSB);
        end else begin
            xs = xe << (cau_pkg::NORM_MSB - int'(r3_p));
            ys = ye << (cau_pkg::NORM_MSB - int'(r3_p));
        end
        n4_ctrl.op       = r3_op;
        n4_ctrl.zf       = r3_zf;
        n4_ctrl.ovf_s    = r3_ovf_s;
        n4_ctrl.neg_re   = r3_neg_re;
        n4_ctrl.neg_im   = r3_neg_im;
        n4_ctrl.big_re   = hi_re >= CW'(den);
        n4_ctrl.big_im   = hi_im >= CW'(den);
        n4_ctrl.a_re_neg = r3_a_re_neg;
        n4_ctrl.a_im_neg = r3_a_im_neg;
        n4_ctrl.x_zero   = (r3_absx == '0);
        n4_ctrl.y_zero   = (r3_absy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ctrl   <= n4_ctrl;
            r4_sre    <= r3_sre;
            r4_sim    <= r3_sim;
            r4_den    <= den;
            r4_rem_re <= hi_re[DW-1:0];
            r4_rem_im <= hi_im[DW-1:0];
            r4_nq_re  <= num_re[W-1:0];
            r4_nq_im  <= num_im[W-1:0];
            r4_sq     <= r3_d;
            r4_x      <= $signed(cau_pkg::CX_W'(xs[cau_pkg::NORM_MSB:0]));
            r4_y      <= $signed(cau_pkg::CX_W'(ys[cau_pkg::NORM_MSB:0]));
        end
    end

    // ---------------- cell row
    logic [DW-1:0]                   w_den    [NC+1];
    logic [DW-1:0]                   w_rem_re [NC+1];
    logic [W-1:0]                    w_nq_re  [NC+1];
    logic [DW-1:0]                   w_rem_im [NC+1];
    logic [W-1:0]                    w_nq_im  [NC+1];
    logic [PW-1:0]                   w_sq     [NC+1];
    logic [W-1:0]                    w_root   [NC+1];
    logic [W:0]                      w_srem   [NC+1];
    logic signed [cau_pkg::CX_W-1:0] w_x      [NC+1];
    logic signed [cau_pkg::CX_W-1:0] w_y      [NC+1];
    logic signed [cau_pkg::Z_W-1:0]  w_z      [NC+1];

    assign w_den[0]    = r4_den;
    assign w_rem_re[0] = r4_rem_re;
    assign w_nq_re[0]  = r4_nq_re;
    assign w_rem_im[0] = r4_rem_im;
    assign w_nq_im[0]  = r4_nq_im;
    assign w_sq[0]     = r4_sq;
    assign w_root[0]   = '0;
    assign w_srem[0]   = '0;
    assign w_x[0]      = r4_x;
    assign w_y[0]      = r4_y;
    assign w_z[0]      = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        cau_cell #(
            .W   (W),
            .IDX (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_den    (w_den[k]),
            .i_rem_re (w_rem_re[k]),
            .i_nq_re  (w_nq_re[k]),
            .i_rem_im (w_rem_im[k]),
            .i_nq_im  (w_nq_im[k]),
            .i_sq     (w_sq[k]),
            .i_root   (w_root[k]),
            .i_srem   (w_srem[k]),
            .i_x      (w_x[k]),
            .i_y      (w_y[k]),
            .i_z      (w_z[k]),
            .o_den    (w_den[k+1]),
            .o_rem_re (w_rem_re[k+1]),
            .o_nq_re  (w_nq_re[k+1]),
            .o_rem_im (w_rem_im[k+1]),
            .o_nq_im  (w_nq_im[k+1]),
            .o_sq     (w_sq[k+1]),
            .o_root   (w_root[k+1]),
            .o_srem   (w_srem[k+1]),
            .o_x      (w_x[k+1]),
            .o_y      (w_y[k+1]),
            .o_z      (w_z[k+1])
        );
    end

    // side data travels alongside the row
    logic [SBW-1:0] r_side [NC];
    logic [NC-1:0]  r_cv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else if (en) begin
            r_cv <= {r_cv[NC-2:0], r4_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= {r4_ctrl, r4_sre, r4_sim};
            for (int k = 1; k < NC; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- result stage
    cau_pkg::t_ctrl            fc;
    logic [W-1:0]              f_sre, f_sim;
    logic [W:0]                f_re, f_im, f_root;
    logic [cau_pkg::ANG_W-1:0] tq, tm;
    logic [RW-1:0]             rv;
    logic                      n_zf;

    always_comb begin
        fc     = cau_pkg::t_ctrl'(r_side[NC-1][SBW-1 -: CTW]);
        f_sre  = r_side[NC-1][2*W-1:W];
        f_sim  = r_side[NC-1][W-1:0];
        f_re   = {fc.ovf_s, f_sre};
        f_im   = {1'b0, f_sim};
        n_zf   = 1'b0;
        f_root = (W+1)'(w_root[NC]) + (W+1)'(w_srem[NC] > (W+1)'(w_root[NC]));
        // first-quadrant angle: axes exact, else clamped rotation sum
        if (fc.y_zero) begin
            tq = '0;
        end else if (fc.x_zero) begin
            tq = cau_pkg::HALF_PI_Q30;
        end else if (w_z[NC][cau_pkg::Z_W-1]) begin
            tq = '0;
        end else if (w_z[NC] > $signed(cau_pkg::Z_W'(cau_pkg::HALF_PI_Q30))) begin
            tq = cau_pkg::HALF_PI_Q30;
        end else begin
            tq = cau_pkg::ANG_W'(w_z[NC]);
        end
        if (fc.a_im_neg) begin
            tm = fc.a_re_neg ? (cau_pkg::PI_Q30 + tq) : (cau_pkg::TWO_PI_Q30 - tq);
        end else begin
            tm = fc.a_re_neg ? (cau_pkg::PI_Q30 - tq) : tq;
        end
        rv = (RW'(tm) + HALF_T) >> RSH;
        if (rv >= FULL) begin
            rv = '0;
        end
        unique case (fc.op) inside
            cau_pkg::OP_DIV, cau_pkg::OP_INV: begin
                n_zf = fc.zf;
                if (!fc.zf) begin
                    f_re = sat_sm(fc.neg_re, fc.big_re, w_nq_re[NC]);
                    f_im = sat_sm(fc.neg_im, fc.big_im, w_nq_im[NC]);
                end
            end
            cau_pkg::OP_MAG: begin
                f_re = sat_sm(1'b0, f_root[W], f_root[W-1:0]);
                f_im = '0;
            end
            cau_pkg::OP_ARG: begin
                f_re = sat_sm(1'b0, |(rv >> W), W'(rv));
                f_im = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_cv[NC-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res_re       <= f_re[W-1:0];
            o_res_im       <= f_im[W-1:0];
            o_zero_operand <= n_zf;
            o_overflow     <= f_re[W] | f_im[W];
        end
    end

endmodule
